[design/ptp_pkg.sv]
`timescale 1ns / 1ps
package ptp_pkg;

  localparam int COORD_BITS = 32;
  localparam int COEF_BITS  = 16;
  localparam int FRAC_BITS  = COORD_BITS / 2;
  localparam int PROD_BITS  = COORD_BITS + COEF_BITS;
  localparam int ACC_BITS   = PROD_BITS + 2;
  localparam int QBITS      = COORD_BITS + 1;
  localparam int MM_LAT     = 2;
  localparam int LANE_LAT   = QBITS + 3;
  localparam int TOTAL_LAT  = MM_LAT + 2 * LANE_LAT;
  localparam int NREGS      = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [63:0] POSE_ROW0_RST = 64'd2048;
  localparam logic [63:0] POSE_ROW1_RST = 64'd134217728;
  localparam logic [63:0] POSE_ROW2_RST = 64'd8796093022208;
  localparam logic [63:0] POSE_ROW3_RST = 64'd576460752303423488;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;

  typedef struct packed {
    logic [ACC_BITS-1:0] rem;
    logic [QBITS-1:0]    low;
    logic [QBITS-1:0]    q;
    logic [ACC_BITS-1:0] den;
    logic                ovf;
    logic                dz;
    logic                nz;
    logic                nneg;
    logic                dneg;
  } step_t;

endpackage

[design/ptp_matmul.sv]
`timescale 1ns / 1ps
module ptp_matmul (
  input  logic                  clk,
  input  logic                  en,
  input  logic [63:0]           pose [4],
  input  ptp_pkg::coord_t       pt [4],
  output ptp_pkg::acc_t         acc [4]
);

  logic signed [ptp_pkg::PROD_BITS-1:0] prod_r [16];
  ptp_pkg::acc_t acc_r [4];

  genvar r, c;
  generate
    for (r = 0; r < 4; r++) begin : g_row
      for (c = 0; c < 4; c++) begin : g_col
        always_ff @(posedge clk) begin
          if (en) begin
            prod_r[r*4+c] <= $signed(pose[r][c*ptp_pkg::COEF_BITS +: ptp_pkg::COEF_BITS])
                             * pt[c];
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          acc_r[r] <= ptp_pkg::ACC_BITS'(prod_r[r*4])   + ptp_pkg::ACC_BITS'(prod_r[r*4+1])
                    + ptp_pkg::ACC_BITS'(prod_r[r*4+2]) + ptp_pkg::ACC_BITS'(prod_r[r*4+3]);
        end
      end
      assign acc[r] = acc_r[r];
    end
  endgenerate

endmodule

[design/ptp_div_lane.sv]
`timescale 1ns / 1ps
module ptp_div_lane (
  input  logic            clk,
  input  logic            en,
  input  ptp_pkg::acc_t   num,
  input  ptp_pkg::acc_t   den,
  output ptp_pkg::coord_t quo,
  output logic            fault
);

  localparam int AW = ptp_pkg::ACC_BITS;
  localparam int QB = ptp_pkg::QBITS;
  localparam int HI = QB - ptp_pkg::FRAC_BITS;

  logic          nneg0_r, dneg0_r;
  logic [AW-1:0] nmag0_r, dmag0_r;
  ptp_pkg::step_t step_r [QB+1];
  ptp_pkg::step_t init_s;
  ptp_pkg::coord_t quo_r, quo_nxt;
  logic fault_r, fault_nxt;

  // magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      nneg0_r <= num[AW-1];
      dneg0_r <= den[AW-1];
      nmag0_r <= num[AW-1] ? AW'(-num) : AW'(num);
      dmag0_r <= den[AW-1] ? AW'(-den) : AW'(den);
    end
  end

  // quotient must stay below 2^QB, else it saturates
  always_comb begin
    init_s      = '0;
    init_s.rem  = AW'(nmag0_r[AW-1:HI]);
    init_s.low  = {nmag0_r[HI-1:0], {ptp_pkg::FRAC_BITS{1'b0}}};
    init_s.den  = dmag0_r;
    init_s.ovf  = (AW'(nmag0_r[AW-1:HI]) >= dmag0_r);
    init_s.dz   = (dmag0_r == '0);
    init_s.nz   = (nmag0_r == '0);
    init_s.nneg = nneg0_r;
    init_s.dneg = dneg0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_r[0] <= init_s;
    end
  end

  genvar i;
  generate
    for (i = 0; i < QB; i++) begin : g_step
      logic [AW:0] t, d;
      logic ge;
      ptp_pkg::step_t s_nxt;
      always_comb begin
        t     = {step_r[i].rem, step_r[i].low[QB-1]};
        d     = t - {1'b0, step_r[i].den};
        ge    = (t >= {1'b0, step_r[i].den});
        s_nxt = step_r[i];
        s_nxt.rem = ge ? d[AW-1:0] : t[AW-1:0];
        s_nxt.low = {step_r[i].low[QB-2:0], 1'b0};
        s_nxt.q   = {step_r[i].q[QB-2:0], ge};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          step_r[i+1] <= s_nxt;
        end
      end
    end
  endgenerate

  // sign, saturation and divide-by-zero result
  always_comb begin
    ptp_pkg::step_t f;
    logic [QB-1:0] qmax, qmin;
    f         = step_r[QB];
    qmax      = {2'b00, {(QB-2){1'b1}}};
    qmin      = {2'b01, {(QB-2){1'b0}}};
    fault_nxt = f.dz;
    if (f.dz) begin
      if (f.nz) begin
        quo_nxt = '0;
      end else if (f.nneg) begin
        quo_nxt = {1'b1, {(ptp_pkg::COORD_BITS-1){1'b0}}};
      end else begin
        quo_nxt = {1'b0, {(ptp_pkg::COORD_BITS-1){1'b1}}};
      end
    end else if ((f.nneg != f.dneg) && (f.ovf || f.q != '0)) begin
      if (f.ovf || f.q > qmin) begin
        quo_nxt = {1'b1, {(ptp_pkg::COORD_BITS-1){1'b0}}};
      end else begin
        quo_nxt = ptp_pkg::COORD_BITS'(~f.q[ptp_pkg::COORD_BITS-1:0] + 1'b1);
      end
    end else begin
      if (f.ovf || f.q > qmax) begin
        quo_nxt = {1'b0, {(ptp_pkg::COORD_BITS-1){1'b1}}};
      end else begin
        quo_nxt = f.q[ptp_pkg::COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r   <= quo_nxt;
      fault_r <= fault_nxt;
    end
  end

  assign quo   = quo_r;
  assign fault = fault_r;

endmodule

[design/point_transform_and_project_core.sv]
`timescale 1ns / 1ps
// Streams homogeneous Q16.16 points through a 4x4 Q4.11 pose matrix, divides by W and then
// by Z, one word per cycle unless the output stalls. The matrix product is registered and
// feeds two restoring dividers in turn, which settle one quotient bit per stage. A stall on the
// output freezes the whole pipeline, so in_stall follows out_stall while a word is waiting.
module point_transform_and_project_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ptp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ptp_pkg::coord_t                   in_obj_x,
  input  ptp_pkg::coord_t                   in_obj_y,
  input  ptp_pkg::coord_t                   in_obj_z,
  input  ptp_pkg::coord_t                   in_obj_w,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ptp_pkg::coord_t                   out_cam_x,
  output ptp_pkg::coord_t                   out_cam_y,
  output ptp_pkg::coord_t                   out_cam_z,
  output ptp_pkg::coord_t                   out_img_x,
  output ptp_pkg::coord_t                   out_img_y,
  output logic                              out_behind_camera,
  output logic                              out_divide_fault
);

  localparam int LL = ptp_pkg::LANE_LAT;

  logic [63:0] pose_r [4];
  logic en;
  logic [ptp_pkg::TOTAL_LAT-1:0] vld_r;
  ptp_pkg::coord_t pt [4];
  ptp_pkg::acc_t acc [4];
  ptp_pkg::coord_t cam [3];
  logic cam_fault [3];
  ptp_pkg::coord_t img [2];
  logic img_fault [2];
  ptp_pkg::coord_t cx_r [LL];
  ptp_pkg::coord_t cy_r [LL];
  ptp_pkg::coord_t cz_r [LL];
  logic cf_r [LL];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_r[0] <= ptp_pkg::POSE_ROW0_RST;
      pose_r[1] <= ptp_pkg::POSE_ROW1_RST;
      pose_r[2] <= ptp_pkg::POSE_ROW2_RST;
      pose_r[3] <= ptp_pkg::POSE_ROW3_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ptp_pkg::REG_ROW0: pose_r[0] <= cfg_data;
        ptp_pkg::REG_ROW1: pose_r[1] <= cfg_data;
        ptp_pkg::REG_ROW2: pose_r[2] <= cfg_data;
        ptp_pkg::REG_ROW3: pose_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ptp_pkg::TOTAL_LAT-2:0], in_valid};
    end
  end

  assign pt[0] = in_obj_x;
  assign pt[1] = in_obj_y;
  assign pt[2] = in_obj_z;
  assign pt[3] = in_obj_w;

  ptp_matmul u_matmul (
    .clk  (clk),
    .en   (en),
    .pose (pose_r),
    .pt   (pt),
    .acc  (acc)
  );

  genvar k;
  generate
    for (k = 0; k < 3; k++) begin : g_cam
      ptp_div_lane u_cam (
        .clk   (clk),
        .en    (en),
        .num   (acc[k]),
        .den   (acc[3]),
        .quo   (cam[k]),
        .fault (cam_fault[k])
      );
    end
    for (k = 0; k < 2; k++) begin : g_img
      ptp_div_lane u_img (
        .clk   (clk),
        .en    (en),
        .num   (ptp_pkg::ACC_BITS'(cam[k])),
        .den   (ptp_pkg::ACC_BITS'(cam[2])),
        .quo   (img[k]),
        .fault (img_fault[k])
      );
    end
  endgenerate

  // camera values wait alongside the second divide
  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= cam[0];
      cy_r[0] <= cam[1];
      cz_r[0] <= cam[2];
      cf_r[0] <= cam_fault[0] | cam_fault[1] | cam_fault[2];
      for (int j = 1; j < LL; j++) begin
        cx_r[j] <= cx_r[j-1];
        cy_r[j] <= cy_r[j-1];
        cz_r[j] <= cz_r[j-1];
        cf_r[j] <= cf_r[j-1];
      end
    end
  end

  assign out_valid         = vld_r[ptp_pkg::TOTAL_LAT-1];
  assign out_cam_x         = cx_r[LL-1];
  assign out_cam_y         = cy_r[LL-1];
  assign out_cam_z         = cz_r[LL-1];
  assign out_img_x         = img[0];
  assign out_img_y         = img[1];
  assign out_behind_camera = cz_r[LL-1][ptp_pkg::COORD_BITS-1];
  assign out_divide_fault  = cf_r[LL-1] | img_fault[0] | img_fault[1];

endmodule

[tb/sv/point_transform_and_project_core_test.sv]
`timescale 1ns / 1ps
module point_transform_and_project_core_test;

  localparam int LIMIT = 600000;
  localparam logic [15:0] ONE_COEF = 16'h0800;
  localparam ptp_pkg::coord_t ONE = 32'h0001_0000;
  localparam ptp_pkg::coord_t CMAX = 32'h7fff_ffff;
  localparam ptp_pkg::coord_t CMIN = 32'h8000_0000;

  typedef struct {
    ptp_pkg::coord_t cx, cy, cz, ix, iy;
    logic   behind, fault;
  } proj_t;

  typedef struct {
    ptp_pkg::coord_t x, y, z, w;
    bit     known;
    proj_t  want;
  } vec_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [ptp_pkg::CFG_IDX_W-1:0] cfg_index = ptp_pkg::REG_ROW0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  ptp_pkg::coord_t in_obj_x = '0, in_obj_y = '0, in_obj_z = '0, in_obj_w = '0;
  logic out_valid;
  logic out_stall = 0;
  ptp_pkg::coord_t out_cam_x, out_cam_y, out_cam_z, out_img_x, out_img_y;
  logic out_behind_camera, out_divide_fault;

  logic [63:0] pose [4];
  proj_t proj_q[$];
  int errors = 0;
  int cyc = 0;
  int stall_mode = 0;

  point_transform_and_project_core u_dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  function automatic longint sat_quot(longint n, longint d, inout bit f);
    logic [63:0] nm, dm;
    logic [127:0] q;
    if (d == 0) begin
      f = 1;
      return (n == 0) ? 0 : (n < 0) ? -64'sd2147483648 : 64'sd2147483647;
    end
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    q = ({64'd0, nm} << ptp_pkg::FRAC_BITS) / {64'd0, dm};
    if (((n < 0) != (d < 0)) && q != 0)
      return (q > 128'd2147483648) ? -64'sd2147483648 : -longint'(q[63:0]);
    return (q > 128'd2147483647) ? 64'sd2147483647 : longint'(q[63:0]);
  endfunction

  function automatic proj_t project(ptp_pkg::coord_t x, ptp_pkg::coord_t y,
                                    ptp_pkg::coord_t z, ptp_pkg::coord_t w);
    ptp_pkg::coord_t p [4];
    longint acc [4];
    longint cam [3];
    logic signed [15:0] k;
    bit f;
    proj_t r;
    p = '{x, y, z, w};
    f = 0;
    for (int i = 0; i < 4; i++) begin
      acc[i] = 0;
      for (int c = 0; c < 4; c++) begin
        k = pose[i][16*c +: 16];
        acc[i] += longint'(k) * longint'(p[c]);
      end
    end
    for (int i = 0; i < 3; i++) cam[i] = sat_quot(acc[i], acc[3], f);
    r.cx = ptp_pkg::coord_t'(cam[0]);
    r.cy = ptp_pkg::coord_t'(cam[1]);
    r.cz = ptp_pkg::coord_t'(cam[2]);
    r.ix = ptp_pkg::coord_t'(sat_quot(cam[0], cam[2], f));
    r.iy = ptp_pkg::coord_t'(sat_quot(cam[1], cam[2], f));
    r.behind = cam[2] < 0;
    r.fault = f;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cyc);
    errors++;
  endtask

  always @(posedge clk) begin
    proj_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (proj_q.size() == 0) begin
        report("unexpected word", out_cam_x, 0);
      end else begin
        e = proj_q.pop_front();
        if (out_cam_x !== e.cx) report("cam_x", out_cam_x, e.cx);
        if (out_cam_y !== e.cy) report("cam_y", out_cam_y, e.cy);
        if (out_cam_z !== e.cz) report("cam_z", out_cam_z, e.cz);
        if (out_img_x !== e.ix) report("img_x", out_img_x, e.ix);
        if (out_img_y !== e.iy) report("img_y", out_img_y, e.iy);
        if (out_behind_camera !== e.behind) report("behind", out_behind_camera, e.behind);
        if (out_divide_fault !== e.fault) report("fault", out_divide_fault, e.fault);
      end
    end
  end

  // receiver back-pressure in one of four randomly chosen modes
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (cyc[5:3] == 3'b101);
    endcase
    if (cyc > LIMIT) begin
      $display("[point_transform_and_project_core] ERROR");
      $finish;
    end
  end

  task automatic send_point(ptp_pkg::coord_t x, ptp_pkg::coord_t y, ptp_pkg::coord_t z,
                            ptp_pkg::coord_t w, bit known, proj_t want);
    in_valid <= 1;
    in_obj_x <= x;
    in_obj_y <= y;
    in_obj_z <= z;
    in_obj_w <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    proj_q.push_back(known ? want : project(x, y, z, w));
  endtask

  task automatic pause(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic load_pose(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                           logic [63:0] r3);
    logic [63:0] rows [4];
    rows = '{r0, r1, r2, r3};
    pause(1);
    while (proj_q.size() != 0) @(posedge clk);
    repeat (ptp_pkg::TOTAL_LAT) @(posedge clk);
    for (int i = 0; i < ptp_pkg::NREGS; i++) begin
      cfg_wr_en <= 1;
      cfg_index <= ptp_pkg::CFG_IDX_W'(i);
      cfg_data <= rows[i];
      pose[i] = rows[i];
      @(posedge clk);
    end
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  function automatic ptp_pkg::coord_t rnd_coord(int sel);
    case (sel)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
      default: return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
    endcase
  endfunction

  function automatic logic [63:0] rnd_row(bit full);
    logic [63:0] r;
    for (int c = 0; c < 4; c++)
      r[16*c +: 16] = full ? 16'($urandom) : 16'($signed($urandom_range(0, 8191)) - 4096);
    return r;
  endfunction

  task automatic random_points(int n);
    int sel, burst;
    ptp_pkg::coord_t x, y, z, w;
    proj_t none;
    none = '{default: 0};
    while (n > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int b = 0; b < burst && n > 0; b++, n--) begin
        sel = $urandom_range(0, 9);
        x = rnd_coord(sel < 6 ? 1 + sel % 2 : 0);
        y = rnd_coord(sel < 6 ? 1 + sel % 2 : 0);
        z = rnd_coord(sel < 6 ? 1 + sel % 2 : 0);
        w = (sel < 4) ? ONE : rnd_coord(sel < 6 ? 2 : 0);
        if (sel == 8) w = 0;
        if (sel == 9) z = 0;
        send_point(x, y, z, w, 0, none);
      end
      if ($urandom_range(0, 1)) pause($urandom_range(1, 12));
    end
  endtask

  initial begin
    vec_t dir_tab [$];
    proj_t none;
    logic [63:0] row3;
    none = '{default: 0};
    pose = '{ptp_pkg::POSE_ROW0_RST, ptp_pkg::POSE_ROW1_RST, ptp_pkg::POSE_ROW2_RST,
             ptp_pkg::POSE_ROW3_RST};
    dir_tab = '{
      '{ONE, 2 * ONE, 4 * ONE, ONE, 1,
        '{32'h1_0000, 32'h2_0000, 32'h4_0000, 32'h4000, 32'h8000, 0, 0}},
      '{ONE, -ONE, 0, 0, 1, '{CMAX, CMIN, 0, CMAX, CMIN, 0, 1}},
      '{0, 0, 0, ONE, 1, '{0, 0, 0, 0, 0, 0, 1}},
      '{2 * ONE, 0, -ONE, ONE, 1,
        '{32'h2_0000, 0, 32'hffff_0000, 32'hfffe_0000, 0, 1, 0}},
      '{CMAX, CMAX, CMAX, CMAX, 0, none},
      '{CMIN, CMIN, CMIN, CMIN, 0, none},
      '{CMAX, CMIN, ONE, 1, 0, none},
      '{CMIN, CMAX, -ONE, -1, 0, none},
      '{ONE, ONE, 1, ONE, 0, none},
      '{-1, 1, CMIN, -ONE, 0, none},
      '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, none},
      '{0, 0, 0, 0, 0, none},
      '{3 * ONE, -5 * ONE, 7 * ONE, -ONE, 0, none},
      '{ONE, ONE, ONE, CMIN, 0, none}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].w,
                 dir_tab[i].known, dir_tab[i].want);
      if (i % 3 == 2) pause($urandom_range(1, 4));
    end
    random_points(200);
    // camera two units in front of the object
    load_pose(64'h0800, 64'h0800_0000, 64'h1000_0800_0000_0000, 64'h0800_0000_0000_0000);
    random_points(200);
    row3 = rnd_row(0);
    row3[63:48] = 16'h0800;
    load_pose(rnd_row(0), rnd_row(0), rnd_row(0), row3);
    random_points(200);
    load_pose({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}});
    random_points(150);
    load_pose({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    random_points(150);
    load_pose(64'h0, 64'h0, 64'h0, 64'h0);
    random_points(60);
    load_pose(rnd_row(1), rnd_row(1), rnd_row(1), rnd_row(1));
    random_points(150);
    load_pose(ptp_pkg::POSE_ROW0_RST, ptp_pkg::POSE_ROW1_RST, ptp_pkg::POSE_ROW2_RST,
              {ONE_COEF, 48'h0});
    random_points(180);
    pause(1);
    while (proj_q.size() != 0) @(posedge clk);
    repeat (ptp_pkg::TOTAL_LAT + 20) @(posedge clk);
    if (errors == 0 && proj_q.size() == 0)
      $display("[point_transform_and_project_core] OK");
    else
      $display("[point_transform_and_project_core] ERROR");
    $finish;
  end

endmodule

[files.f]
design/ptp_pkg.sv
design/ptp_matmul.sv
design/ptp_div_lane.sv
design/point_transform_and_project_core.sv
tb/sv/point_transform_and_project_core_test.sv
